@@ rtl/line_rectangle_clip_assert.svh @@
// ----------------------------------------------------------------------------
// Line rectangle clip assertion macros
// Shared property forms for the checks in the clipping pipeline.
// ----------------------------------------------------------------------------
`ifndef LINE_RECTANGLE_CLIP_ASSERT_SVH
`define LINE_RECTANGLE_CLIP_ASSERT_SVH

// Condition holds in the same cycle as the antecedent.
`define LRC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition holds after the antecedent, delayed by the argument n.
`define LRC_ASSERT_DLY(label, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
    else $error(msg);

`endif

@@ rtl/lrc_pkg.sv @@
// ----------------------------------------------------------------------------
// Line rectangle clip package
// Widths, latencies, register indexes and shared types of the clipper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrc_pkg;

  localparam int COEF_W        = 16;
  localparam int CONST_W       = 32;
  localparam int SIDE_W        = 13;
  localparam int MAX_SIDE      = 4096;
  localparam int OUT_FRAC_BITS = 4;
  localparam int COORD_W       = 17;
  localparam int PROD_W        = COEF_W + SIDE_W + 1;
  localparam int SUM_W         = CONST_W + 2;
  localparam int NUM_W         = SUM_W + OUT_FRAC_BITS;
  localparam int DIV_LAT       = COORD_W + 3;
  localparam int PIPE_LAT      = DIV_LAT + 5;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic               found;
    logic [3:0]         hit;
    logic [COORD_W-1:0] wq;
    logic [COORD_W-1:0] hq;
  } side_t;

  function automatic logic [SIDE_W-1:0] side_clamp(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = SIDE_W'(1);
    end else if (v > SIDE_W'(MAX_SIDE)) begin
      res = SIDE_W'(MAX_SIDE);
    end
    return res;
  endfunction

endpackage

@@ rtl/line_rectangle_clip.sv @@
// Throughput: one request per cycle; busy stays low, the receiver cannot stall.
// Most of the latency lies in the four 17-stage quotient pipelines, one per edge.
// Reset is synchronous and active low; it clears all valid bits and sets both
// rectangle sides to 1024.
// ----------------------------------------------------------------------------
// Line rectangle clip
// Clips the line a*x + b*y + c = 0 against the configured rectangle and
// reports the two crossing points in edge order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "line_rectangle_clip_assert.svh"

module line_rectangle_clip (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lrc_pkg::ADDR_W-1:0]          paddr,
  input  logic [lrc_pkg::DATA_W-1:0]          pwdata,
  output logic [lrc_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [lrc_pkg::COEF_W-1:0]   in_coef_x,
  input  logic signed [lrc_pkg::COEF_W-1:0]   in_coef_y,
  input  logic signed [lrc_pkg::CONST_W-1:0]  in_coef_const,
  output logic                                out_valid,
  output logic                                out_found,
  output logic [lrc_pkg::COORD_W-1:0]         out_first_x,
  output logic [lrc_pkg::COORD_W-1:0]         out_first_y,
  output logic [lrc_pkg::COORD_W-1:0]         out_second_x,
  output logic [lrc_pkg::COORD_W-1:0]         out_second_y
);

  localparam int CW = lrc_pkg::COORD_W;
  localparam int SW = lrc_pkg::SIDE_W;
  localparam int FB = lrc_pkg::OUT_FRAC_BITS;

  logic [SW-1:0] width_r;
  logic [SW-1:0] height_r;
  logic          wr_en;
  lrc_pkg::reg_idx_t wr_idx;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_idx = lrc_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SW'(1024);
      height_r <= SW'(1024);
    end else if (wr_en) begin
      case (wr_idx)
        lrc_pkg::REG_WIDTH:  width_r  <= pwdata[SW-1:0];
        lrc_pkg::REG_HEIGHT: height_r <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      lrc_pkg::REG_WIDTH:  prdata = lrc_pkg::DATA_W'(width_r);
      lrc_pkg::REG_HEIGHT: prdata = lrc_pkg::DATA_W'(height_r);
      default:             prdata = '0;
    endcase
  end

  // Stage 1: request capture with the sides clamped.
  logic                                v1_r;
  logic signed [lrc_pkg::COEF_W-1:0]   a1_r, b1_r;
  logic signed [lrc_pkg::CONST_W-1:0]  c1_r;
  logic [SW-1:0]                       w1_r, h1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    a1_r <= in_coef_x;
    b1_r <= in_coef_y;
    c1_r <= in_coef_const;
    w1_r <= lrc_pkg::side_clamp(width_r);
    h1_r <= lrc_pkg::side_clamp(height_r);
  end

  // Stage 2: products a*W and b*H.
  logic                                v2_r;
  logic signed [lrc_pkg::PROD_W-1:0]   aw2_r, bh2_r;
  logic signed [lrc_pkg::CONST_W-1:0]  c2_r;
  logic signed [lrc_pkg::COEF_W-1:0]   a2_r, b2_r;
  logic [SW-1:0]                       w2_r, h2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    aw2_r <= a1_r * $signed({1'b0, w1_r});
    bh2_r <= b1_r * $signed({1'b0, h1_r});
    c2_r  <= c1_r;
    a2_r  <= a1_r;
    b2_r  <= b1_r;
    w2_r  <= w1_r;
    h2_r  <= h1_r;
  end

  // Stage 3: line value at the four vertices.
  logic                               v3_r;
  logic signed [lrc_pkg::SUM_W-1:0]   s0_r, s1_r, s2_r, s3_r;
  logic signed [lrc_pkg::COEF_W-1:0]  a3_r, b3_r;
  logic [SW-1:0]                      w3_r, h3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    s0_r <= lrc_pkg::SUM_W'(c2_r);
    s1_r <= lrc_pkg::SUM_W'(aw2_r) + lrc_pkg::SUM_W'(c2_r);
    s2_r <= lrc_pkg::SUM_W'(aw2_r) + lrc_pkg::SUM_W'(bh2_r) + lrc_pkg::SUM_W'(c2_r);
    s3_r <= lrc_pkg::SUM_W'(bh2_r) + lrc_pkg::SUM_W'(c2_r);
    a3_r <= a2_r;
    b3_r <= b2_r;
    w3_r <= w2_r;
    h3_r <= h2_r;
  end

  // Stage 4: crossed edges and the scaled numerators.
  function automatic logic crossing(input logic signed [lrc_pkg::SUM_W-1:0] p,
                                    input logic signed [lrc_pkg::SUM_W-1:0] q);
    logic p_neg, q_neg, p_pos, q_pos;
    p_neg = p[lrc_pkg::SUM_W-1];
    q_neg = q[lrc_pkg::SUM_W-1];
    p_pos = !p_neg && (p != '0);
    q_pos = !q_neg && (q != '0);
    return (p_neg && q_pos) || (p_pos && q_neg);
  endfunction

  function automatic logic signed [lrc_pkg::NUM_W-1:0] scale_neg(
      input logic signed [lrc_pkg::SUM_W-1:0] s);
    logic signed [lrc_pkg::NUM_W-1:0] t;
    t = lrc_pkg::NUM_W'(s);
    return -(t <<< FB);
  endfunction

  logic                               v4_r;
  logic signed [lrc_pkg::NUM_W-1:0]   n0_r, n1_r, n2_r;
  logic signed [lrc_pkg::COEF_W-1:0]  a4_r, b4_r;
  lrc_pkg::side_t                     side4_r;
  logic [3:0]                         hit_nxt;

  always_comb begin
    hit_nxt[0] = crossing(s0_r, s1_r);
    hit_nxt[1] = crossing(s1_r, s2_r);
    hit_nxt[2] = crossing(s2_r, s3_r);
    hit_nxt[3] = crossing(s3_r, s0_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    n0_r          <= scale_neg(s0_r);
    n1_r          <= scale_neg(s1_r);
    n2_r          <= scale_neg(s3_r);
    a4_r          <= a3_r;
    b4_r          <= b3_r;
    side4_r.hit   <= hit_nxt;
    side4_r.found <= ($countones(hit_nxt) == 2);
    side4_r.wq    <= CW'(w3_r) << FB;
    side4_r.hq    <= CW'(h3_r) << FB;
  end

  // Quotients: bottom x, right y, top x, left y.
  logic [3:0]    div_vld;
  logic [CW-1:0] q0, q1, q2, q3;

  lrc_div #(.NUM_W(lrc_pkg::NUM_W), .DEN_W(lrc_pkg::COEF_W), .Q_W(CW)) u_div_bottom (
    .clk(clk), .rst_n(rst_n), .in_valid(v4_r), .in_num(n0_r), .in_den(a4_r),
    .in_limit(side4_r.wq), .out_valid(div_vld[0]), .out_quo(q0)
  );

  lrc_div #(.NUM_W(lrc_pkg::NUM_W), .DEN_W(lrc_pkg::COEF_W), .Q_W(CW)) u_div_right (
    .clk(clk), .rst_n(rst_n), .in_valid(v4_r), .in_num(n1_r), .in_den(b4_r),
    .in_limit(side4_r.hq), .out_valid(div_vld[1]), .out_quo(q1)
  );

  lrc_div #(.NUM_W(lrc_pkg::NUM_W), .DEN_W(lrc_pkg::COEF_W), .Q_W(CW)) u_div_top (
    .clk(clk), .rst_n(rst_n), .in_valid(v4_r), .in_num(n2_r), .in_den(a4_r),
    .in_limit(side4_r.wq), .out_valid(div_vld[2]), .out_quo(q2)
  );

  lrc_div #(.NUM_W(lrc_pkg::NUM_W), .DEN_W(lrc_pkg::COEF_W), .Q_W(CW)) u_div_left (
    .clk(clk), .rst_n(rst_n), .in_valid(v4_r), .in_num(n0_r), .in_den(b4_r),
    .in_limit(side4_r.hq), .out_valid(div_vld[3]), .out_quo(q3)
  );

  lrc_pkg::side_t side_r [0:lrc_pkg::DIV_LAT-1];

  always_ff @(posedge clk) begin
    side_r[0] <= side4_r;
  end

  for (genvar k = 1; k < lrc_pkg::DIV_LAT; k++) begin : g_side
    always_ff @(posedge clk) begin
      side_r[k] <= side_r[k-1];
    end
  end

  // Output stage: pick the first and last crossed edge.
  lrc_pkg::side_t side_o;
  logic [CW-1:0]  fx_nxt, fy_nxt, sx_nxt, sy_nxt;

  assign side_o = side_r[lrc_pkg::DIV_LAT-1];

  always_comb begin
    fx_nxt = '0;
    fy_nxt = '0;
    sx_nxt = '0;
    sy_nxt = '0;
    if (side_o.found) begin
      if (side_o.hit[0]) begin
        fx_nxt = q0;
      end else if (side_o.hit[1]) begin
        fx_nxt = side_o.wq;
        fy_nxt = q1;
      end else begin
        fx_nxt = q2;
        fy_nxt = side_o.hq;
      end
      if (side_o.hit[3]) begin
        sy_nxt = q3;
      end else if (side_o.hit[2]) begin
        sx_nxt = q2;
        sy_nxt = side_o.hq;
      end else begin
        sx_nxt = side_o.wq;
        sy_nxt = q1;
      end
    end
  end

  logic          out_valid_r;
  logic          out_found_r;
  logic [CW-1:0] fx_r, fy_r, sx_r, sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_vld[0];
    end
    out_found_r <= side_o.found;
    fx_r        <= fx_nxt;
    fy_r        <= fy_nxt;
    sx_r        <= sx_nxt;
    sy_r        <= sy_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_first_x  = fx_r;
  assign out_first_y  = fy_r;
  assign out_second_x = sx_r;
  assign out_second_y = sy_r;

  `LRC_ASSERT_DLY(a_latency, start && !busy, lrc_pkg::PIPE_LAT, out_valid, "result missing after request")
  `LRC_ASSERT_IMP(a_div_align, 1'b1, (div_vld == 4'b0000) || (div_vld == 4'b1111), "dividers out of step")
  `LRC_ASSERT_IMP(a_found_two, div_vld[0] && side_o.found, $countones(side_o.hit) == 2, "found without two crossings")
  `LRC_ASSERT_IMP(a_miss_zero, out_valid && !out_found, (out_first_x == '0) && (out_first_y == '0) && (out_second_x == '0) && (out_second_y == '0), "points not cleared")

endmodule

@@ rtl/lrc_div.sv @@
// ----------------------------------------------------------------------------
// Line rectangle clip divider
// Pipelined restoring divider, one quotient bit per stage, with the quotient
// truncated toward zero and saturated to the range zero to a given limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrc_div #(
  parameter int NUM_W = lrc_pkg::NUM_W,
  parameter int DEN_W = lrc_pkg::COEF_W,
  parameter int Q_W   = lrc_pkg::COORD_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic signed [NUM_W-1:0] in_num,
  input  logic signed [DEN_W-1:0] in_den,
  input  logic [Q_W-1:0]          in_limit,
  output logic                    out_valid,
  output logic [Q_W-1:0]          out_quo
);

  localparam int HI_W = NUM_W - Q_W;

  logic             a_vld_r;
  logic [NUM_W-1:0] a_num_r;
  logic [DEN_W-1:0] a_den_r;
  logic             a_neg_r;
  logic [Q_W-1:0]   a_lim_r;

  logic             vld_r [0:Q_W];
  logic [DEN_W-1:0] rem_r [0:Q_W];
  logic [Q_W-1:0]   num_r [0:Q_W];
  logic [DEN_W-1:0] den_r [0:Q_W];
  logic [Q_W-1:0]   quo_r [0:Q_W];
  logic             neg_r [0:Q_W];
  logic             ovf_r [0:Q_W];
  logic [Q_W-1:0]   lim_r [0:Q_W];

  logic             out_vld_r;
  logic [Q_W-1:0]   out_quo_r;
  logic [HI_W-1:0]  hi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_valid;
    end
    a_num_r <= in_num[NUM_W-1] ? NUM_W'(-in_num) : NUM_W'(in_num);
    a_den_r <= in_den[DEN_W-1] ? DEN_W'(-in_den) : DEN_W'(in_den);
    a_neg_r <= in_num[NUM_W-1] ^ in_den[DEN_W-1];
    a_lim_r <= in_limit;
  end

  assign hi = a_num_r[NUM_W-1:Q_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= a_vld_r;
    end
    rem_r[0] <= hi[DEN_W-1:0];
    num_r[0] <= a_num_r[Q_W-1:0];
    den_r[0] <= a_den_r;
    quo_r[0] <= '0;
    neg_r[0] <= a_neg_r;
    ovf_r[0] <= hi >= HI_W'(a_den_r);
    lim_r[0] <= a_lim_r;
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W:0]   diff;
    logic [DEN_W-1:0] rem_nxt;
    logic [Q_W-1:0]   quo_nxt;

    always_comb begin
      trial   = {rem_r[k], num_r[k][Q_W-1-k]};
      ge      = trial >= {1'b0, den_r[k]};
      diff    = trial - {1'b0, den_r[k]};
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_nxt = quo_r[k];
      quo_nxt[Q_W-1-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      rem_r[k+1] <= rem_nxt;
      num_r[k+1] <= num_r[k];
      den_r[k+1] <= den_r[k];
      quo_r[k+1] <= quo_nxt;
      neg_r[k+1] <= neg_r[k];
      ovf_r[k+1] <= ovf_r[k];
      lim_r[k+1] <= lim_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[Q_W];
    end
    if (neg_r[Q_W]) begin
      out_quo_r <= '0;
    end else if (ovf_r[Q_W] || (quo_r[Q_W] > lim_r[Q_W])) begin
      out_quo_r <= lim_r[Q_W];
    end else begin
      out_quo_r <= quo_r[Q_W];
    end
  end

  assign out_valid = out_vld_r;
  assign out_quo   = out_quo_r;

endmodule

@@ dv/tb_line_rectangle_clip.sv @@
// ----------------------------------------------------------------------------
// Line rectangle clip testbench
// Sends line requests to the clipper under several rectangle sizes, predicts
// each untyped row's crossing pair in 64-bit integers and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_line_rectangle_clip;

  typedef struct packed {
    logic                        found;
    logic [lrc_pkg::COORD_W-1:0] fx;
    logic [lrc_pkg::COORD_W-1:0] fy;
    logic [lrc_pkg::COORD_W-1:0] sx;
    logic [lrc_pkg::COORD_W-1:0] sy;
  } clip_t;

  typedef struct {
    logic signed [lrc_pkg::COEF_W-1:0]  a;
    logic signed [lrc_pkg::COEF_W-1:0]  b;
    logic signed [lrc_pkg::CONST_W-1:0] c;
    bit                                 typed;
    clip_t                              res;
  } row_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [lrc_pkg::ADDR_W-1:0]          paddr = '0;
  logic [lrc_pkg::DATA_W-1:0]          pwdata = '0;
  logic [lrc_pkg::DATA_W-1:0]          prdata;
  logic                                pready;
  logic                                start = 1'b0;
  logic                                busy;
  logic signed [lrc_pkg::COEF_W-1:0]   in_coef_x = '0;
  logic signed [lrc_pkg::COEF_W-1:0]   in_coef_y = '0;
  logic signed [lrc_pkg::CONST_W-1:0]  in_coef_const = '0;
  logic                                out_valid;
  logic                                out_found;
  logic [lrc_pkg::COORD_W-1:0]         out_first_x, out_first_y, out_second_x, out_second_y;

  logic [lrc_pkg::SIDE_W-1:0] rect_w = 13'd1024;
  logic [lrc_pkg::SIDE_W-1:0] rect_h = 13'd1024;
  clip_t                      pending_clips[$];
  int                         mismatches = 0;
  bit                         gaps_on = 1'b1;

  line_rectangle_clip dut (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .in_coef_x(in_coef_x), .in_coef_y(in_coef_y),
    .in_coef_const(in_coef_const), .out_valid(out_valid), .out_found(out_found),
    .out_first_x(out_first_x), .out_first_y(out_first_y),
    .out_second_x(out_second_x), .out_second_y(out_second_y)
  );

  always #1 clk = ~clk;

  function automatic longint eff_side(logic [lrc_pkg::SIDE_W-1:0] v);
    if (v == 0) return 1;
    if (v > lrc_pkg::MAX_SIDE) return lrc_pkg::MAX_SIDE;
    return longint'(v);
  endfunction

  function automatic clip_t clip_line(longint a, longint b, longint c);
    longint w, h, px, py, qx, qy, sp, sq, e0, e1, e2, n0, n1, d, one, x, y;
    longint vx[4], vy[4];
    clip_t  r;
    int     cnt, slot;
    logic [2*lrc_pkg::COORD_W-1:0] pts[4];
    bit     hit[4];
    w = eff_side(rect_w);
    h = eff_side(rect_h);
    one = longint'(1) << lrc_pkg::OUT_FRAC_BITS;
    vx = '{0, w, w, 0};
    vy = '{0, 0, h, h};
    cnt = 0;
    for (int i = 0; i < 4; i++) begin
      px = vx[i]; py = vy[i]; qx = vx[(i + 1) % 4]; qy = vy[(i + 1) % 4];
      sp = a * px + b * py + c;
      sq = a * qx + b * qy + c;
      hit[i] = 1'b0;
      pts[i] = '0;
      if ((sp < 0 && sq > 0) || (sp > 0 && sq < 0)) begin
        e0 = py - qy;
        e1 = qx - px;
        e2 = px * qy - py * qx;
        n0 = e1 * c - e2 * b;
        n1 = e2 * a - e0 * c;
        d = e0 * b - e1 * a;
        if (d != 0) begin
          x = (n0 * one) / d;
          y = (n1 * one) / d;
          x = (x < 0) ? 0 : (x > w * one) ? w * one : x;
          y = (y < 0) ? 0 : (y > h * one) ? h * one : y;
          hit[i] = 1'b1;
          pts[i] = {x[lrc_pkg::COORD_W-1:0], y[lrc_pkg::COORD_W-1:0]};
          cnt++;
        end
      end
    end
    r = '0;
    if (cnt == 2) begin
      r.found = 1'b1;
      slot = 0;
      for (int i = 0; i < 4; i++) begin
        if (hit[i]) begin
          if (slot == 0) {r.fx, r.fy} = pts[i];
          else {r.sx, r.sy} = pts[i];
          slot++;
        end
      end
    end
    return r;
  endfunction

  task automatic send_line(row_t rw);
    start <= 1'b1;
    in_coef_x <= rw.a;
    in_coef_y <= rw.b;
    in_coef_const <= rw.c;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_clips.push_back(rw.typed ? rw.res : clip_line(rw.a, rw.b, rw.c));
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic write_reg(lrc_pkg::reg_idx_t idx, logic [lrc_pkg::DATA_W-1:0] val);
    start <= 1'b0;
    while (pending_clips.size() != 0) @(posedge clk);
    repeat (lrc_pkg::PIPE_LAT + 5) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= lrc_pkg::ADDR_W'(4 * idx);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == lrc_pkg::REG_WIDTH) rect_w = val[lrc_pkg::SIDE_W-1:0];
    else rect_h = val[lrc_pkg::SIDE_W-1:0];
  endtask

  function automatic row_t random_line();
    row_t   rw;
    longint a, b, cc;
    rw.typed = 1'b0;
    rw.res = '0;
    rw.a = lrc_pkg::COEF_W'($urandom);
    rw.b = lrc_pkg::COEF_W'($urandom);
    rw.c = lrc_pkg::CONST_W'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      // Put the line through a point inside the rectangle so it usually crosses.
      if ($urandom_range(0, 2) == 0) rw.a = lrc_pkg::COEF_W'($urandom_range(0, 255) - 128);
      a = rw.a;
      b = rw.b;
      cc = -(a * $urandom_range(0, eff_side(rect_w)) + b * $urandom_range(0, eff_side(rect_h)));
      if (cc > 32'sh7fffffff) cc = 32'sh7fffffff;
      if (cc < -64'sd2147483648) cc = -64'sd2147483648;
      rw.c = cc[lrc_pkg::CONST_W-1:0];
    end
    return rw;
  endfunction

  always @(posedge clk) begin
    clip_t got, want;
    if (rst_n && out_valid) begin
      got = {out_found, out_first_x, out_first_y, out_second_x, out_second_y};
      if (pending_clips.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_clips.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected f=%0d %0d,%0d %0d,%0d got f=%0d %0d,%0d %0d,%0d",
                     want.found, want.fx, want.fy, want.sx, want.sy,
                     got.found, got.fx, got.fy, got.sx, got.sy);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("line_rectangle_clip: mismatch");
    $finish;
  end

  initial begin
    row_t        table_rows[$];
    int unsigned sizes[6][2];
    table_rows = '{
      '{16'sd0, 16'sd0, 32'sd0, 1'b1, clip_t'('0)},
      '{16'sd0, 16'sd0, -32'sd5, 1'b1, clip_t'('0)},
      '{16'sd16384, 16'sd0, -32'sd8388608, 1'b1, '{1'b1, 17'd8192, 17'd0, 17'd8192, 17'd16384}},
      '{16'sd0, 16'sd16384, -32'sd8388608, 1'b1, '{1'b1, 17'd16384, 17'd8192, 17'd0, 17'd8192}},
      '{16'sd16384, 16'sd16384, 32'sd0, 1'b1, clip_t'('0)},
      '{16'sd16384, -16'sd16384, 32'sd0, 1'b1, clip_t'('0)},
      '{16'sd16384, 16'sd16384, -32'sd33554432, 1'b1, clip_t'('0)},
      '{16'sd16384, 16'sd16384, 32'sd1, 1'b1, clip_t'('0)},
      '{-16'sd32768, 16'sd32767, 32'sd0, 1'b0, clip_t'('0)},
      '{16'sd32767, -16'sd32768, -32'sd2147483648, 1'b0, clip_t'('0)},
      '{-16'sd32768, -16'sd32768, 32'sd2147483647, 1'b0, clip_t'('0)},
      '{16'sd32767, 16'sd32767, -32'sd2147483648, 1'b0, clip_t'('0)},
      '{16'sd1, -16'sd1, 32'sd7, 1'b0, clip_t'('0)},
      '{16'sd100, 16'sd3, -32'sd51200, 1'b0, clip_t'('0)},
      '{-16'sd16384, 16'sd8192, 32'sd2000000, 1'b0, clip_t'('0)},
      '{16'sd16384, 16'sd0, -32'sd1, 1'b0, clip_t'('0)},
      '{16'sd0, -16'sd16384, 32'sd16777215, 1'b0, clip_t'('0)}
    };
    sizes = '{'{1, 1}, '{0, 4096}, '{4096, 0}, '{8191, 4095}, '{5000, 7}, '{0, 0}};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (table_rows[i]) send_line(table_rows[i]);
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) begin
        sizes[ph][0] = $urandom_range(1, 4096);
        sizes[ph][1] = $urandom_range(1, 4096);
        gaps_on = 1'b0;
      end
      write_reg(lrc_pkg::REG_WIDTH,
                lrc_pkg::DATA_W'({$urandom, 13'h0} | sizes[ph][0]));
      write_reg(lrc_pkg::REG_HEIGHT,
                lrc_pkg::DATA_W'({$urandom, 13'h0} | sizes[ph][1]));
      repeat (150) send_line(random_line());
    end
    start <= 1'b0;
    while (pending_clips.size() != 0) @(posedge clk);
    repeat (lrc_pkg::PIPE_LAT + 5) @(posedge clk);
    if (mismatches == 0) $display("line_rectangle_clip: match");
    else $display("line_rectangle_clip: mismatch");
    $finish;
  end

endmodule
